[rtl/core/mtbg_pkg.sv]
package mtbg_pkg;

  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;

  localparam int DEF_STATE_WORDS = 351;
  localparam int DEF_MIDDLE_OFFSET = 175;

  localparam int SPLIT_BIT = 19;
  localparam logic [WORD_W-1:0] LOW_PART_MASK = WORD_W'((64'd1 << SPLIT_BIT) - 64'd1);
  localparam logic [WORD_W-1:0] HIGH_PART_MASK = ~LOW_PART_MASK;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'hE4BD75F5;
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h655E5280;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hFFD58000;
  localparam logic [WORD_W-1:0] SEED_MULT = 32'd29943829;

  localparam int TEMPER_U = 11;
  localparam int TEMPER_S = 7;
  localparam int TEMPER_T = 15;
  localparam int TEMPER_L = 17;

  typedef enum logic [0:0] {
    OP_DRAW = 1'b0,
    OP_RESEED = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DRAW = 3'b010,
    S_SEED = 3'b100
  } state_t;

endpackage

[rtl/core/mtbg_ram.sv]
module mtbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/mtbg_twist.sv]
module mtbg_twist import mtbg_pkg::*; (
  input  logic [WORD_W-1:0] hi_src,
  input  logic [WORD_W-1:0] lo_src,
  input  logic [WORD_W-1:0] mid,
  output logic [WORD_W-1:0] new_word,
  output logic [WORD_W-1:0] tempered
);

  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;
  logic [WORD_W-1:0] t3;

  always_comb begin
    y = (hi_src & HIGH_PART_MASK) | (lo_src & LOW_PART_MASK);
    new_word = mid ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
    t1 = new_word ^ (new_word >> TEMPER_U);
    t2 = t1 ^ ((t1 << TEMPER_S) & TEMPER_B);
    t3 = t2 ^ ((t2 << TEMPER_T) & TEMPER_C);
    tempered = t3 ^ (t3 >> TEMPER_L);
  end

endmodule

[rtl/core/mersenne_twister_byte_generator.sv]
// Mersenne Twister byte generator (MT11213A variant: 351 words, middle offset 175).
// The word state lives in two mirrored single-port-read RAMs, and the twist is done
// lazily: each draw regenerates exactly one word in place from the cached current word,
// the next word and the word 175 places ahead, then tempers it. A draw first accepts
// with the registered RAM read, then twists, tempers and writes back, waiting there
// while the output is stalled. A reseed makes one RAM write per word through the seed
// multiplier, and returns no result. Until the first reseed after reset the state
// RAMs are not written and every draw returns zero; no clearing pass is needed.
module mersenne_twister_byte_generator import mtbg_pkg::*; #(
  parameter int STATE_WORDS = DEF_STATE_WORDS,
  parameter int MIDDLE_OFFSET = DEF_MIDDLE_OFFSET
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [0:0]        opcode,
  input  logic [WORD_W-1:0] seed,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] random_byte,
  output logic [WORD_W-1:0] tempered_word
);

  localparam int IDX_W = $clog2(STATE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W:0] MID_OFS = (IDX_W+1)'(MIDDLE_OFFSET);
  localparam logic [IDX_W:0] WRAP = (IDX_W+1)'(STATE_WORDS);

  state_t state;
  state_t state_next;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] seed_count;
  logic seeded;
  logic [WORD_W-1:0] s;
  logic [WORD_W-1:0] s_next;
  logic [WORD_W-1:0] cur_word;

  logic in_accept;
  logic draw_accept;
  logic draw_done;
  logic seeding;
  logic [IDX_W-1:0] next_addr;
  logic [IDX_W:0] mid_sum;
  logic [IDX_W-1:0] mid_addr;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] next_word;
  logic [WORD_W-1:0] mid_word;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] tempered;

  assign in_stall = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign draw_accept = in_accept && (opcode == OP_DRAW);
  assign draw_done = (state == S_DRAW) && (!out_valid || !out_stall);
  assign seeding = (state == S_SEED);

  always_comb begin
    next_addr = (ptr == LAST_IDX) ? '0 : ptr + IDX_W'(1);
    mid_sum = {1'b0, ptr} + MID_OFS;
    mid_addr = (mid_sum >= WRAP) ? IDX_W'(mid_sum - WRAP) : mid_sum[IDX_W-1:0];
    s_next = WORD_W'(s * SEED_MULT) - WORD_W'(1);
    wr_en = seeding || (draw_done && seeded);
    wr_addr = seeding ? seed_count : ptr;
    wr_data = seeding ? s_next : new_word;
  end

  // Two mirrored copies give the two reads each draw needs.
  mtbg_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram_next (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (draw_accept),
    .rd_addr (next_addr),
    .rd_data (next_word)
  );

  mtbg_ram #(.WIDTH(WORD_W), .DEPTH(STATE_WORDS)) u_ram_mid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (draw_accept),
    .rd_addr (mid_addr),
    .rd_data (mid_word)
  );

  mtbg_twist u_twist (
    .hi_src   (cur_word),
    .lo_src   (next_word),
    .mid      (mid_word),
    .new_word (new_word),
    .tempered (tempered)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (opcode == OP_RESEED) ? S_SEED : S_DRAW;
        end
      end
      S_DRAW: begin
        if (draw_done) begin
          state_next = S_IDLE;
        end
      end
      S_SEED: begin
        if (seed_count == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr <= '0;
      seed_count <= '0;
      seeded <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (draw_done) begin
        out_valid <= 1'b1;
        if (seeded) begin
          ptr <= next_addr;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_accept && (opcode == OP_RESEED)) begin
        seed_count <= '0;
      end else if (seeding) begin
        seed_count <= (seed_count == LAST_IDX) ? '0 : seed_count + IDX_W'(1);
        if (seed_count == LAST_IDX) begin
          seeded <= 1'b1;
          ptr <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (opcode == OP_RESEED)) begin
      s <= seed;
    end else if (seeding) begin
      s <= s_next;
    end
    // Hold word 0 as the current word for the first draw after a reseed.
    if (seeding && (seed_count == '0)) begin
      cur_word <= s_next;
    end else if (draw_done && seeded) begin
      cur_word <= next_word;
    end
    if (draw_done) begin
      tempered_word <= seeded ? tempered : '0;
      random_byte <= seeded ? tempered[BYTE_W-1:0] : '0;
    end
  end

  a_draw_enters_draw: assert property (@(posedge clk) disable iff (rst)
    draw_accept |=> (state == S_DRAW))
    else $error("draw request did not start a draw");

  a_result_from_draw: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DRAW))
    else $error("result appeared without a draw");

  a_seed_end: assert property (@(posedge clk) disable iff (rst)
    (seeding && (seed_count == LAST_IDX)) |=> ((ptr == '0) && seeded && (state == S_IDLE)))
    else $error("reseed did not restart the index");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (ptr <= LAST_IDX) && (seed_count <= LAST_IDX))
    else $error("index out of range");

endmodule
